// File: design/glrd_pkg.sv
// Shared types, codes and helpers for the glyph run-length decoder.
package glrd_pkg;

   localparam int unsigned ROW_BITS = 32;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_ROW    = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;
   localparam logic [1:0] KIND_FLAG   = 2'd3;

   // record parse phases
   localparam logic [2:0] PH_CODE   = 3'd0;
   localparam logic [2:0] PH_SIZE   = 3'd1;
   localparam logic [2:0] PH_PFX_HI = 3'd2;
   localparam logic [2:0] PH_PFX_LO = 3'd3;
   localparam logic [2:0] PH_BITS   = 3'd4;
   localparam logic [2:0] PH_SKIP   = 3'd5;

   // configuration register indexes
   localparam logic [2:0] CSR_BG_RUN  = 3'd0;
   localparam logic [2:0] CSR_FG_RUN  = 3'd1;
   localparam logic [2:0] CSR_WIDTH   = 3'd2;
   localparam logic [2:0] CSR_HEIGHT  = 3'd3;
   localparam logic [2:0] CSR_XOFF    = 3'd4;
   localparam logic [2:0] CSR_YOFF    = 3'd5;
   localparam logic [2:0] CSR_ADVANCE = 3'd6;

   typedef struct packed {
      logic [ROW_BITS-1:0] row_pixels;
      logic [4:0]          row_index;
      logic [7:0]          advance;
      logic [7:0]          y_offset;
      logic [7:0]          x_offset;
      logic [7:0]          glyph_height;
      logic [7:0]          glyph_width;
      logic [15:0]         code_point;
      logic [1:0]          kind;
      logic                last_result;
   } result_type;

   // field widths above 8 behave as 8
   function automatic logic [3:0] clamp8(input logic [3:0] v);
      clamp8 = (v > 4'd8) ? 4'd8 : v;
   endfunction

endpackage

// File: design/bitmap_font_glyph_rle_decoder.sv
// Glyph-area byte decoder of a run-length coded bitmap font.
//
// req_ takes one font byte per word (tlast marks the final byte of the font).
// rsp_ gives result words: tuser is the kind (header, row, end, flag) and
// tlast marks the last result that a byte causes. csr_ writes the seven
// field-width registers; the user must do so only while the block is idle,
// which the block does not enforce. Each accepted byte runs through a small
// sequencer that uses one bit-field extractor and one row-segment unit. A
// byte that only moves the record phase steps through accept, phase,
// last-byte check and flush. A size or bitstream byte adds one step per
// header or run field taken, one for the field that finds too few bits, one
// for the header word, up to two per run pair to switch between runs, one per
// row segment (a segment ends at a run end or a row end) and one to settle
// the record. A byte marked last adds one for the end word. req_tready is
// high only between bytes. Results go through a one-word staging register and
// a one-word output register; the sequencer stops at a result only when both
// are full. Synchronous reset clears all state and valid flags to zero; after
// the end of the font every byte is taken and gives no result until reset.
module bitmap_font_glyph_rle_decoder #(
   parameter int unsigned MAX_WIDTH  = 32,
   parameter int unsigned MAX_HEIGHT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] font_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // code_point, glyph_width, glyph_height, x_offset,
                                    // y_offset, advance, row_index, row_pixels, zero pad
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // last_result
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [3:0]  csr_wdata
);
   import glrd_pkg::*;

   localparam int unsigned MAX_RESULTS = MAX_HEIGHT + 2;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BYTE  = 4'd1;
   localparam logic [3:0] S_DEC   = 4'd2;
   localparam logic [3:0] S_HDR   = 4'd3;
   localparam logic [3:0] S_FILL  = 4'd4;
   localparam logic [3:0] S_POST  = 4'd5;
   localparam logic [3:0] S_LAST  = 4'd6;
   localparam logic [3:0] S_END   = 4'd7;
   localparam logic [3:0] S_FLUSH = 4'd8;

   logic [3:0] cfg_ff [7];

   logic [3:0]  state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  code_ff, code_in;
   logic [15:0] prefix_ff, prefix_in;
   logic [15:0] buf_ff, buf_in;
   logic [4:0]  held_ff, held_in;
   logic [2:0]  fidx_ff, fidx_in;
   logic [7:0]  wid_ff, wid_in, hgt_ff, hgt_in;
   logic [7:0]  xoff_ff, xoff_in, yoff_ff, yoff_in, adv_ff, adv_in;
   logic [7:0]  bgrun_ff, bgrun_in, fgrun_ff, fgrun_in;
   logic [7:0]  col_ff, col_in, row_ff, row_in;
   logic [ROW_BITS-1:0] rowst_ff, rowst_in;
   logic [7:0]  runleft_ff, runleft_in;
   logic        fillfg_ff, fillfg_in;
   logic        done_ff, done_in;
   logic        ended_ff, ended_in;
   logic [7:0]  byte_ff, byte_in;
   logic        lastb_ff, lastb_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic        pend_v_ff, pend_v_in, out_v_ff, out_v_in;
   result_type  pend_ff, pend_in, out_ff, out_in;

   logic        emit_req, flush_req, out_free, emit_ok, capped, emit_fire;
   logic        flush_fire, seq_go;
   result_type  emit_pl, glyph_pl;

   logic [3:0]  take_n;
   logic [7:0]  field_val;
   logic [15:0] bits_rest;
   logic [7:0]  half_val;

   logic [7:0]  wcol, seg_k;
   logic [8:0]  end_col, next_row;
   logic        row_done;
   logic [ROW_BITS-1:0] seg_mask, new_row;

   glrd_take u_take (
      .bits_buf  (buf_ff),
      .take_n    (take_n),
      .field_val (field_val),
      .bits_rest (bits_rest)
   );

   always_comb begin
      unique case (fidx_ff)
         3'd0:    take_n = clamp8(cfg_ff[CSR_WIDTH]);
         3'd1:    take_n = clamp8(cfg_ff[CSR_HEIGHT]);
         3'd2:    take_n = clamp8(cfg_ff[CSR_XOFF]);
         3'd3:    take_n = clamp8(cfg_ff[CSR_YOFF]);
         3'd4:    take_n = clamp8(cfg_ff[CSR_ADVANCE]);
         3'd5:    take_n = clamp8(cfg_ff[CSR_BG_RUN]);
         3'd6:    take_n = clamp8(cfg_ff[CSR_FG_RUN]);
         default: take_n = 4'd1;
      endcase
   end

   // bias of a signed header field: half its range
   assign half_val = (take_n == 4'd0) ? 8'd0 : 8'(9'd1 << (take_n - 4'd1));

   // row segment unit
   assign wcol     = wid_ff - col_ff;
   assign seg_k    = (runleft_ff < wcol) ? runleft_ff : wcol;
   assign end_col  = {1'b0, col_ff} + {1'b0, seg_k};
   assign row_done = end_col >= {1'b0, wid_ff};
   assign next_row = {1'b0, row_ff} + 9'd1;
   always_comb begin
      for (int i = 0; i < ROW_BITS; i++) begin
         seg_mask[i] = fillfg_ff && (9'(i) >= {1'b0, col_ff}) && (9'(i) < end_col);
      end
   end
   assign new_row = rowst_ff | seg_mask;

   always_comb begin
      glyph_pl              = '0;
      glyph_pl.code_point   = {prefix_ff[15:8], code_ff};
      glyph_pl.glyph_width  = wid_ff;
      glyph_pl.glyph_height = hgt_ff;
      glyph_pl.x_offset     = xoff_ff;
      glyph_pl.y_offset     = yoff_ff;
      glyph_pl.advance      = adv_ff;
   end

   assign out_free = !out_v_ff || rsp_tready;
   assign emit_ok  = !pend_v_ff || out_free;
   assign capped   = cnt_ff >= CNT_W'(MAX_RESULTS);

   always_comb begin
      state_in = state_ff;   phase_in = phase_ff;   left_in = left_ff;
      code_in = code_ff;     prefix_in = prefix_ff; buf_in = buf_ff;
      held_in = held_ff;     fidx_in = fidx_ff;     wid_in = wid_ff;
      hgt_in = hgt_ff;       xoff_in = xoff_ff;     yoff_in = yoff_ff;
      adv_in = adv_ff;       bgrun_in = bgrun_ff;   fgrun_in = fgrun_ff;
      col_in = col_ff;       row_in = row_ff;       rowst_in = rowst_ff;
      runleft_in = runleft_ff; fillfg_in = fillfg_ff; done_in = done_ff;
      ended_in = ended_ff;   byte_in = byte_ff;     lastb_in = lastb_ff;
      cnt_in = cnt_ff;
      emit_req  = 1'b0;
      flush_req = 1'b0;
      emit_pl   = glyph_pl;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cnt_in = '0;
               if (!ended_ff) begin
                  byte_in  = req_tdata;
                  lastb_in = req_tlast;
                  state_in = S_BYTE;
               end
            end
         end
         S_BYTE: begin
            state_in = S_LAST;
            unique case (phase_ff)
               PH_CODE: begin
                  code_in  = byte_ff;
                  phase_in = PH_SIZE;
               end
               PH_SIZE: begin
                  if (byte_ff == 8'd0) begin
                     phase_in = PH_PFX_HI;
                  end else begin
                     buf_in = '0; held_in = '0; fidx_in = '0;
                     wid_in = '0; hgt_in = '0; xoff_in = '0; yoff_in = '0; adv_in = '0;
                     bgrun_in = '0; fgrun_in = '0; col_in = '0; row_in = '0;
                     rowst_in = '0;
                     done_in = 1'b0;
                     left_in = (byte_ff == 8'd1) ? 8'd0 : byte_ff - 8'd2;
                     // a size of one flags at once through the wrap-up path
                     state_in = (byte_ff == 8'd1) ? S_POST : S_DEC;
                  end
               end
               PH_PFX_HI: begin
                  prefix_in = {byte_ff, 8'd0};
                  phase_in  = PH_PFX_LO;
               end
               PH_PFX_LO: begin
                  prefix_in = {prefix_ff[15:8], byte_ff};
                  phase_in  = PH_CODE;
                  if ({prefix_ff[15:8], byte_ff} == 16'd0) begin
                     emit_req = 1'b1;
                     emit_pl  = '0;
                     emit_pl.kind = KIND_END;
                     ended_in = 1'b1;
                  end
               end
               PH_BITS: begin
                  buf_in  = buf_ff | ({8'd0, byte_ff} << held_ff);
                  held_in = held_ff + 5'd8;
                  left_in = left_ff - 8'd1;
                  state_in = S_DEC;
               end
               default: begin
                  left_in = left_ff - 8'd1;
                  if (left_ff == 8'd1) phase_in = PH_CODE;
               end
            endcase
         end
         S_DEC: begin
            if (held_ff < {1'b0, take_n}) begin
               done_in  = 1'b0;
               state_in = S_POST;
            end else begin
               buf_in  = bits_rest;
               held_in = held_ff - {1'b0, take_n};
               unique case (fidx_ff)
                  3'd0: begin wid_in = field_val; fidx_in = 3'd1; end
                  3'd1: begin hgt_in = field_val; fidx_in = 3'd2; end
                  3'd2: begin xoff_in = field_val - half_val; fidx_in = 3'd3; end
                  3'd3: begin yoff_in = field_val - half_val; fidx_in = 3'd4; end
                  3'd4: begin
                     adv_in   = field_val - half_val;
                     fidx_in  = 3'd5;
                     state_in = S_HDR;
                  end
                  3'd5: begin bgrun_in = field_val; fidx_in = 3'd6; end
                  3'd6: begin
                     fgrun_in   = field_val;
                     runleft_in = bgrun_ff;
                     fillfg_in  = 1'b0;
                     state_in   = S_FILL;
                  end
                  default: begin
                     // repeat bit replays the same run pair
                     if (field_val[0]) begin
                        runleft_in = bgrun_ff;
                        fillfg_in  = 1'b0;
                        state_in   = S_FILL;
                     end else begin
                        fidx_in = 3'd5;
                     end
                  end
               endcase
            end
         end
         S_HDR: begin
            emit_req = 1'b1;
            if (wid_ff > 8'(MAX_WIDTH) || hgt_ff > 8'(MAX_HEIGHT)) begin
               emit_pl.kind = KIND_FLAG;
               done_in  = 1'b1;
               state_in = S_POST;
            end else begin
               emit_pl.kind = KIND_HEADER;
               if (wid_ff == 8'd0 || hgt_ff == 8'd0) begin
                  done_in  = 1'b1;
                  state_in = S_POST;
               end else begin
                  state_in = S_DEC;
               end
            end
         end
         S_FILL: begin
            if (runleft_ff == 8'd0) begin
               if (!fillfg_ff) begin
                  runleft_in = fgrun_ff;
                  fillfg_in  = 1'b1;
               end else begin
                  fidx_in  = 3'd7;
                  state_in = S_DEC;
               end
            end else begin
               runleft_in = runleft_ff - seg_k;
               if (row_done) begin
                  emit_req = 1'b1;
                  emit_pl.kind       = KIND_ROW;
                  emit_pl.row_index  = row_ff[4:0];
                  emit_pl.row_pixels = new_row;
                  rowst_in = '0;
                  col_in   = '0;
                  row_in   = next_row[7:0];
                  if (next_row >= {1'b0, hgt_ff}) begin
                     done_in  = 1'b1;
                     state_in = S_POST;
                  end
               end else begin
                  col_in   = end_col[7:0];
                  rowst_in = new_row;
               end
            end
         end
         S_POST: begin
            state_in = S_LAST;
            if (done_ff) begin
               phase_in = (left_ff != 8'd0) ? PH_SKIP : PH_CODE;
            end else if (left_ff == 8'd0) begin
               emit_req = 1'b1;
               emit_pl.kind = KIND_FLAG;
               phase_in = PH_CODE;
            end else begin
               phase_in = PH_BITS;
            end
         end
         S_LAST: begin
            state_in = S_FLUSH;
            if (lastb_ff && !ended_ff) begin
               state_in = S_END;
               if (phase_ff == PH_SIZE || phase_ff == PH_BITS || phase_ff == PH_SKIP) begin
                  emit_req = 1'b1;
                  emit_pl.kind = KIND_FLAG;
               end
            end
         end
         S_END: begin
            emit_req = 1'b1;
            emit_pl  = '0;
            emit_pl.kind = KIND_END;
            ended_in = 1'b1;
            phase_in = PH_CODE;
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            flush_req = pend_v_ff;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      emit_fire  = emit_req && !capped && emit_ok;
      flush_fire = flush_req && out_free;
      seq_go     = (!emit_req || capped || emit_ok) && (!flush_req || out_free);
      if (emit_fire) cnt_in = cnt_ff + CNT_W'(1);
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      out_in    = out_ff;
      out_v_in  = out_v_ff && !rsp_tready;
      if (emit_fire) begin
         pend_v_in = 1'b1;
         pend_in   = emit_pl;
         if (pend_v_ff) begin
            out_in   = pend_ff;
            out_in.last_result = 1'b0;
            out_v_in = 1'b1;
         end
      end else if (flush_fire) begin
         pend_v_in = 1'b0;
         out_in    = pend_ff;
         out_in.last_result = 1'b1;
         out_v_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 7; i++) cfg_ff[i] <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BG_RUN, CSR_FG_RUN, CSR_WIDTH, CSR_HEIGHT,
            CSR_XOFF, CSR_YOFF, CSR_ADVANCE: cfg_ff[csr_addr] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;   phase_ff <= PH_CODE; left_ff <= '0;
         code_ff <= '0;        prefix_ff <= '0;     buf_ff <= '0;
         held_ff <= '0;        fidx_ff <= '0;       wid_ff <= '0;
         hgt_ff <= '0;         xoff_ff <= '0;       yoff_ff <= '0;
         adv_ff <= '0;         bgrun_ff <= '0;      fgrun_ff <= '0;
         col_ff <= '0;         row_ff <= '0;        rowst_ff <= '0;
         runleft_ff <= '0;     fillfg_ff <= 1'b0;   done_ff <= 1'b0;
         ended_ff <= 1'b0;     byte_ff <= '0;       lastb_ff <= 1'b0;
         cnt_ff <= '0;
         pend_v_ff <= 1'b0;    out_v_ff <= 1'b0;
      end else begin
         if (seq_go) begin
            state_ff <= state_in;   phase_ff <= phase_in;   left_ff <= left_in;
            code_ff <= code_in;     prefix_ff <= prefix_in; buf_ff <= buf_in;
            held_ff <= held_in;     fidx_ff <= fidx_in;     wid_ff <= wid_in;
            hgt_ff <= hgt_in;       xoff_ff <= xoff_in;     yoff_ff <= yoff_in;
            adv_ff <= adv_in;       bgrun_ff <= bgrun_in;   fgrun_ff <= fgrun_in;
            col_ff <= col_in;       row_ff <= row_in;       rowst_ff <= rowst_in;
            runleft_ff <= runleft_in; fillfg_ff <= fillfg_in; done_ff <= done_in;
            ended_ff <= ended_in;   byte_ff <= byte_in;     lastb_ff <= lastb_in;
            cnt_ff <= cnt_in;
         end
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last_result;
   assign rsp_tdata  = {3'd0, out_ff.row_pixels, out_ff.row_index, out_ff.advance,
                        out_ff.y_offset, out_ff.x_offset, out_ff.glyph_height,
                        out_ff.glyph_width, out_ff.code_point};
endmodule

// File: design/glrd_take.sv
// Bit-field extractor: takes the low n bits (n up to 8) off the bit buffer.
module glrd_take (
   input  logic [15:0] bits_buf,
   input  logic [3:0]  take_n,
   output logic [7:0]  field_val,
   output logic [15:0] bits_rest
);
   logic [8:0] field_mask;

   assign field_mask = (9'd1 << take_n) - 9'd1;
   assign field_val  = bits_buf[7:0] & field_mask[7:0];
   assign bits_rest  = bits_buf >> take_n;
endmodule

// File: design/glrd_checker.sv
// Port-level checks on the result channel of the glyph decoder.
module glrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import glrd_pkg::*;

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled result word changed");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tlast)
      else $error("end of font is not the last result of its byte");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tdata == '0)
      else $error("end of font carries nonzero fields");

   a_pix_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_ROW |-> rsp_tdata[92:56] == '0)
      else $error("row fields set on a non-row result");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
endmodule

bind bitmap_font_glyph_rle_decoder glrd_checker u_glrd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: bench/tb_bitmap_font_glyph_rle_decoder.sv
// Testbench of the glyph run-length decoder: scoreboard of predicted result words.
module tb_bitmap_font_glyph_rle_decoder;
   import glrd_pkg::*;

   localparam int MAX_W = 32;
   localparam int MAX_H = 32;
   localparam int MAX_PER_BYTE = MAX_H + 2;
   localparam int DRAIN_CYCLES = 300;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] code_point;
      logic [7:0]  width;
      logic [7:0]  height;
      logic [7:0]  x_off;
      logic [7:0]  y_off;
      logic [7:0]  adv;
      logic [4:0]  row_idx;
      logic [31:0] pixels;
      logic        last;
   } glyph_word_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 0;
   logic [2:0]  csr_addr = CSR_BG_RUN;
   logic [3:0]  csr_wdata = 0;

   bitmap_font_glyph_rle_decoder dut (.*);

   always #2 clock = ~clock;

   // decoder shadow state
   logic [3:0]  field_bits [7];
   logic [2:0]  phase;
   logic [7:0]  bytes_left, code_lo;
   logic [15:0] prefix, bitbuf, dims;
   logic [4:0]  held;
   logic [2:0]  fidx;
   logic [23:0] offs;
   logic [7:0]  bg_len, fg_len, col, row;
   logic [31:0] row_bits;
   bit          ended;
   int          step_words;

   glyph_word_type pending_words[$];
   int  errors = 0;
   int  send_idle_pct = 0, recv_idle_pct = 0;
   int  bytes_sent = 0;
   bit  bits_q[$];

   function automatic int fbits(int i);
      return (field_bits[i] > 8) ? 8 : int'(field_bits[i]);
   endfunction

   function automatic void push_word(logic [1:0] k, logic [7:0] r, logic [31:0] px);
      glyph_word_type w;
      if (step_words >= MAX_PER_BYTE) return;
      w.kind = k;
      w.code_point = (k == KIND_END) ? 16'h0 : ((prefix & 16'hFF00) | code_lo);
      w.width  = (k == KIND_END) ? 8'h0 : dims[7:0];
      w.height = (k == KIND_END) ? 8'h0 : dims[15:8];
      w.x_off  = (k == KIND_END) ? 8'h0 : offs[7:0];
      w.y_off  = (k == KIND_END) ? 8'h0 : offs[15:8];
      w.adv    = (k == KIND_END) ? 8'h0 : offs[23:16];
      w.row_idx = r[4:0];
      w.pixels = px;
      w.last = 0;
      pending_words.push_back(w);
      step_words++;
   endfunction

   function automatic int take_bits(int n);
      int v;
      v = bitbuf & ((1 << n) - 1);
      bitbuf = bitbuf >> n;
      held = held - n;
      return v;
   endfunction

   function automatic bit advance_column();
      col++;
      if (col >= dims[7:0]) begin
         push_word(KIND_ROW, row, row_bits);
         row_bits = 0;
         col = 0;
         row++;
         if (row >= dims[15:8]) return 1;
      end
      return 0;
   endfunction

   function automatic bit paint_runs();
      for (int j = 0; j < bg_len; j++)
         if (advance_column()) return 1;
      for (int j = 0; j < fg_len; j++) begin
         if (col < 32) row_bits[col[4:0]] = 1'b1;
         if (advance_column()) return 1;
      end
      return 0;
   endfunction

   function automatic bit unpack_glyph();
      int n, v, sv;
      forever begin
         if (fidx < 5) begin
            n = fbits(CSR_WIDTH + fidx);
            if (held < n) return 0;
            v = take_bits(n);
            if (fidx == 0) dims = v;
            else if (fidx == 1) dims[15:8] = v;
            else begin
               sv = n ? ((v - (1 << (n - 1))) & 8'hFF) : 0;
               offs = offs | (24'(sv) << (8 * (fidx - 2)));
            end
            fidx++;
            if (fidx == 5) begin
               if (dims[7:0] > MAX_W || dims[15:8] > MAX_H) begin
                  push_word(KIND_FLAG, 0, 0);
                  return 1;
               end
               push_word(KIND_HEADER, 0, 0);
               if (dims[7:0] == 0 || dims[15:8] == 0) return 1;
            end
         end else if (fidx == 5) begin
            n = fbits(CSR_BG_RUN);
            if (held < n) return 0;
            bg_len = take_bits(n);
            fidx = 6;
         end else if (fidx == 6) begin
            n = fbits(CSR_FG_RUN);
            if (held < n) return 0;
            fg_len = take_bits(n);
            if (paint_runs()) return 1;
            fidx = 7;
         end else begin
            if (held < 1) return 0;
            if (take_bits(1)) begin
               if (paint_runs()) return 1;
            end else fidx = 5;
         end
      end
   endfunction

   function automatic void settle(bit done);
      if (done) phase = bytes_left ? PH_SKIP : PH_CODE;
      else if (bytes_left == 0) begin
         push_word(KIND_FLAG, 0, 0);
         phase = PH_CODE;
      end else phase = PH_BITS;
   endfunction

   function automatic void clear_glyph();
      bitbuf = 0; held = 0; fidx = 0; dims = 0; offs = 0;
      bg_len = 0; fg_len = 0; col = 0; row = 0; row_bits = 0;
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic lst);
      step_words = 0;
      if (ended) return;
      case (phase)
         PH_CODE: begin
            code_lo = b;
            phase = PH_SIZE;
         end
         PH_SIZE: begin
            if (b == 0) phase = PH_PFX_HI;
            else if (b == 1) begin
               clear_glyph();
               push_word(KIND_FLAG, 0, 0);
               phase = PH_CODE;
            end else begin
               bytes_left = b - 2;
               clear_glyph();
               settle(unpack_glyph());
            end
         end
         PH_PFX_HI: begin
            prefix = {b, 8'h00};
            phase = PH_PFX_LO;
         end
         PH_PFX_LO: begin
            prefix[7:0] = b;
            phase = PH_CODE;
            if (prefix == 0) begin
               push_word(KIND_END, 0, 0);
               ended = 1;
            end
         end
         PH_BITS: begin
            bitbuf = bitbuf | (16'(b) << held);
            held = held + 8;
            bytes_left--;
            settle(unpack_glyph());
         end
         default: begin
            bytes_left--;
            if (bytes_left == 0) phase = PH_CODE;
         end
      endcase
      if (lst && !ended) begin
         if (phase == PH_SIZE || phase == PH_BITS || phase == PH_SKIP)
            push_word(KIND_FLAG, 0, 0);
         push_word(KIND_END, 0, 0);
         ended = 1;
         phase = PH_CODE;
      end
      if (step_words > 0) pending_words[$].last = 1;
   endfunction

   // ---------------- driving ----------------
   task automatic send_byte(input logic [7:0] b, input logic lst = 0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= b;
      req_tlast <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b, lst);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      field_bits[idx] = val;
      @(negedge clock);
   endtask

   task automatic load_regs(input int bg, fg, w, h, x, y, a);
      wait_idle();
      write_reg(CSR_BG_RUN, 4'(bg));
      write_reg(CSR_FG_RUN, 4'(fg));
      write_reg(CSR_WIDTH, 4'(w));
      write_reg(CSR_HEIGHT, 4'(h));
      write_reg(CSR_XOFF, 4'(x));
      write_reg(CSR_YOFF, 4'(y));
      write_reg(CSR_ADVANCE, 4'(a));
      csr_we <= 0;
      @(negedge clock);
   endtask

   function automatic void put_bits(int v, int n);
      for (int i = 0; i < n; i++) bits_q.push_back(v[i]);
   endfunction

   // one glyph record; trim drops bitstream bytes, pad adds tail bytes
   task automatic send_glyph(input int w, h, trim, pad, input logic [7:0] code);
      int covered, bgv, fgv, nbytes, size;
      logic [7:0] b;
      bits_q.delete();
      put_bits(w, fbits(CSR_WIDTH));
      put_bits(h, fbits(CSR_HEIGHT));
      put_bits($urandom, fbits(CSR_XOFF));
      put_bits($urandom, fbits(CSR_YOFF));
      put_bits($urandom, fbits(CSR_ADVANCE));
      covered = 0;
      for (int p = 0; p < 40 && covered < w * h; p++) begin
         bgv = $urandom & ((1 << fbits(CSR_BG_RUN)) - 1);
         fgv = $urandom & ((1 << fbits(CSR_FG_RUN)) - 1);
         put_bits(bgv, fbits(CSR_BG_RUN));
         put_bits(fgv, fbits(CSR_FG_RUN));
         covered += bgv + fgv;
         if ($urandom_range(3) == 0) begin
            put_bits(1, 1);
            covered += bgv + fgv;
         end else put_bits(0, 1);
      end
      nbytes = (bits_q.size() + 7) / 8 - trim;
      if (nbytes < 0) nbytes = 0;
      size = 2 + nbytes + pad;
      if (size > 255) size = 255;
      send_byte(code);
      send_byte(size);
      for (int i = 0; i < size - 2; i++) begin
         b = $urandom;
         for (int k = 0; k < 8; k++)
            if (i * 8 + k < bits_q.size()) b[k] = bits_q[i * 8 + k];
         send_byte(b);
      end
   endtask

   // ---------------- checking ----------------
   task automatic cmp(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      glyph_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, got kind %0d data %0h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            w = pending_words.pop_front();
            cmp("kind", w.kind, rsp_tuser);
            cmp("code_point", w.code_point, rsp_tdata[15:0]);
            cmp("glyph_width", w.width, rsp_tdata[23:16]);
            cmp("glyph_height", w.height, rsp_tdata[31:24]);
            cmp("x_offset", w.x_off, rsp_tdata[39:32]);
            cmp("y_offset", w.y_off, rsp_tdata[47:40]);
            cmp("advance", w.adv, rsp_tdata[55:48]);
            cmp("row_index", w.row_idx, rsp_tdata[60:56]);
            cmp("row_pixels", w.pixels, rsp_tdata[92:61]);
            cmp("pad", 0, rsp_tdata[95:93]);
            cmp("last_result", w.last, rsp_tlast);
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("tb_bitmap_font_glyph_rle_decoder failed");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_reset_config();
      // all field widths zero: every glyph is empty and done at its size byte
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'hFF);
      send_byte(8'h05);
      repeat (3) send_byte($urandom);
   endtask

   task automatic test_directed();
      load_regs(8, 8, 8, 8, 8, 8, 8);
      send_byte(8'h20); send_byte(8'h00); send_byte(8'h12); send_byte(8'hFF); // block marker
      send_glyph(200, 3, 0, 0, 8'h41);   // oversize width, tail skipped
      send_glyph(4, 40, 0, 1, 8'hFF);    // oversize height
      send_byte(8'h7E); send_byte(8'h01); // size one flags at once
      load_regs(2, 3, 4, 4, 3, 3, 3);
      send_glyph(5, 3, 0, 2, 8'h00);     // complete early, extra bytes skipped
      send_glyph(6, 4, 2, 0, 8'h42);     // short record
      send_glyph(0, 5, 0, 0, 8'h43);     // empty glyph
      load_regs(15, 15, 6, 6, 1, 0, 12);
      send_glyph(32, 2, 0, 0, 8'h44);    // full-width rows, values above 8 clamp
   endtask

   task automatic random_phase(input int nbytes, input bit hold_off);
      int first;
      first = bytes_sent;
      while (bytes_sent - first < nbytes) begin
         if (hold_off && pending_words.size() != 0) begin
            req_tvalid <= 0;
            while (pending_words.size() != 0) @(negedge clock);
         end
         case ($urandom_range(9))
            0: begin
               send_byte($urandom);
               send_byte(8'h00);
               send_byte($urandom_range(1, 255));
               send_byte($urandom);
            end
            1: begin
               send_byte($urandom); send_byte($urandom_range(1, 3));
            end
            2: begin
               send_glyph($urandom_range(33, 255), $urandom_range(1, 40), 0,
                          $urandom_range(0, 2), $urandom);
            end
            3: begin
               send_glyph($urandom_range(1, 12), $urandom_range(1, 8),
                          $urandom_range(1, 3), 0, $urandom);
            end
            default: begin
               send_glyph($urandom_range(0, 10), $urandom_range(0, 6), 0,
                          $urandom_range(0, 2), $urandom);
            end
         endcase
      end
   endtask

   task automatic test_random();
      send_idle_pct = 35; recv_idle_pct = 45;
      load_regs(3, 2, 4, 3, 4, 5, 6);
      random_phase(100, 0);
      send_idle_pct = 45; recv_idle_pct = 35;
      load_regs(1, 4, 6, 5, 8, 2, 0);
      random_phase(35, 1);
      load_regs(4, 4, 5, 5, 0, 8, 2);
      random_phase(80, 0);
      send_idle_pct = 0; recv_idle_pct = 0;
      load_regs(8, 1, 7, 6, 3, 3, 8);
      random_phase(70, 0);
      load_regs(0, 0, 3, 2, 2, 2, 2);
      random_phase(35, 0);
   endtask

   task automatic test_font_end();
      load_regs(2, 2, 4, 4, 4, 4, 4);
      case ($urandom_range(2))
         0: begin // zero prefix ends the font
            send_byte($urandom); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
         end
         1: begin // last byte inside a glyph bitstream
            send_byte($urandom); send_byte(8'h09); send_byte($urandom);
            send_byte($urandom, 1);
         end
         default: begin // last byte inside a block marker
            send_byte($urandom); send_byte(8'h00); send_byte($urandom, 1);
         end
      endcase
      repeat (6) send_byte($urandom, $urandom_range(1));
   endtask

   initial begin
      for (int i = 0; i < 7; i++) field_bits[i] = 0;
      phase = PH_CODE; bytes_left = 0; code_lo = 0; prefix = 0; ended = 0;
      clear_glyph();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_reset_config();
      test_directed();
      test_random();
      test_font_end();
      req_tvalid <= 0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && pending_words.size() == 0)
         $display("tb_bitmap_font_glyph_rle_decoder passed");
      else
         $display("tb_bitmap_font_glyph_rle_decoder failed");
      $finish;
   end

endmodule

// File: sim.f
design/glrd_pkg.sv
design/glrd_take.sv
design/bitmap_font_glyph_rle_decoder.sv
design/glrd_checker.sv
bench/tb_bitmap_font_glyph_rle_decoder.sv
